/* rtl/core/fractional_baud_divisor_calc_assert.svh */
// Assertion macros for the fractional baud divisor calculator.
// Depends on nothing; included by the RTL files that carry assertions.
`ifndef FRACTIONAL_BAUD_DIVISOR_CALC_ASSERT_SVH
`define FRACTIONAL_BAUD_DIVISOR_CALC_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/fbdc_pkg.sv */
// Shared widths, codes, reset values and side-band types of the baud divisor calculator.
// Depends on nothing; imported by every module of the block.
package fbdc_pkg;

	localparam int BAUD_W   = 22;
	localparam int CLK_W    = 27;
	localparam int MUL_W    = 2;
	localparam int DL_W     = 16;
	localparam int BYTE_W   = 8;
	localparam int FRAC_W   = 11;
	localparam int WORD_W   = 16;
	localparam int STATUS_W = 2;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USED_W = DL_W + 2 * BYTE_W + FRAC_W + WORD_W;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

	// First division: clock_hz / (32 * (M + 1) * baud)
	localparam int DIV1_SHIFT = 5;
	localparam int DIV1_NUM_W = CLK_W;
	localparam int DIV1_DEN_W = BAUD_W + MUL_W + 1 + DIV1_SHIFT;
	localparam int DIV1_QUO_W = CLK_W - DIV1_SHIFT;

	// Second division: 64 * clock_hz / (baud * DL)
	localparam int DIV2_SHIFT = 6;
	localparam int DIV2_NUM_W = CLK_W + DIV2_SHIFT;
	localparam int DIV2_DEN_W = BAUD_W + DL_W;
	localparam int DIV2_QUO_W = FRAC_W + MUL_W;

	localparam int WORD_PAD_W = WORD_W - 1 - MUL_W - FRAC_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = CLK_W;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAC_MULT = 2'd1;

	localparam logic [CLK_W-1:0] CLOCK_HZ_RST  = 27'd41779200;
	localparam logic [MUL_W-1:0] FRAC_MULT_RST = 2'd1;

	localparam int DIVISOR_LIMIT_DEF = 65000;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_DIV   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_HIGH = 2'd2;

	// Side band carried through the first divider
	typedef struct packed {
		logic [BAUD_W-1:0] baud;
		logic [CLK_W-1:0]  clk_hz;
		logic [MUL_W-1:0]  mult;
	} side1_t;

	// Side band carried through the second divider
	typedef struct packed {
		logic [DL_W-1:0]  dl;
		logic [MUL_W-1:0] mult;
		logic             no_div;
	} side2_t;

endpackage

/* rtl/core/fbdc_div_stage.sv */
// One restoring-division step: resolves a single quotient bit and registers the result.
// Depends on fbdc_pkg for default widths.
module fbdc_div_stage import fbdc_pkg::*; #(
	parameter int NUM_W  = DIV1_NUM_W,
	parameter int DEN_W  = DIV1_DEN_W,
	parameter int QUO_W  = DIV1_QUO_W,
	parameter int BIT    = 0,
	parameter int SIDE_W = $bits(side1_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_rem,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [QUO_W-1:0]  in_quo,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  out_rem,
	output logic [DEN_W-1:0]  out_den,
	output logic [QUO_W-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	localparam int CW = (NUM_W > DEN_W) ? NUM_W : DEN_W;
	localparam int WW = CW + QUO_W;

	logic [CW-1:0]     rem_hi;
	logic              take;
	logic [WW-1:0]     den_sh;
	logic [NUM_W-1:0]  rem_nx;
	logic [QUO_W-1:0]  quo_nx;

	logic              valid_q;
	logic [NUM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUO_W-1:0]  quo_q;
	logic [SIDE_W-1:0] side_q;

	// rem >= den << BIT, compared without widening the remainder
	always_comb begin
		rem_hi = CW'(in_rem >> BIT);
		take   = rem_hi >= CW'(in_den);
		den_sh = WW'(in_den) << BIT;
		rem_nx = take ? (in_rem - den_sh[NUM_W-1:0]) : in_rem;
		quo_nx = in_quo;
		quo_nx[BIT] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_nx;
			den_q  <= in_den;
			quo_q  <= quo_nx;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_den   = den_q;
	assign out_quo   = quo_q;
	assign out_side  = side_q;

endmodule

/* rtl/core/fbdc_divider.sv */
// Pipelined restoring divider, one quotient bit per register stage, MSB first.
// Depends on fbdc_pkg and fbdc_div_stage.
module fbdc_divider import fbdc_pkg::*; #(
	parameter int NUM_W  = DIV1_NUM_W,
	parameter int DEN_W  = DIV1_DEN_W,
	parameter int QUO_W  = DIV1_QUO_W,
	parameter int SIDE_W = $bits(side1_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_c  [0:QUO_W];
	logic [NUM_W-1:0]  rem_c  [0:QUO_W];
	logic [DEN_W-1:0]  den_c  [0:QUO_W];
	logic [QUO_W-1:0]  quo_c  [0:QUO_W];
	logic [SIDE_W-1:0] side_c [0:QUO_W];

	assign vld_c[0]  = in_valid;
	assign rem_c[0]  = num;
	assign den_c[0]  = den;
	assign quo_c[0]  = '0;
	assign side_c[0] = in_side;

	for (genvar g = 0; g < QUO_W; g++) begin : g_step
		fbdc_div_stage #(
			.NUM_W  (NUM_W),
			.DEN_W  (DEN_W),
			.QUO_W  (QUO_W),
			.BIT    (QUO_W - 1 - g),
			.SIDE_W (SIDE_W)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld_c[g]),
			.in_rem    (rem_c[g]),
			.in_den    (den_c[g]),
			.in_quo    (quo_c[g]),
			.in_side   (side_c[g]),
			.out_valid (vld_c[g+1]),
			.out_rem   (rem_c[g+1]),
			.out_den   (den_c[g+1]),
			.out_quo   (quo_c[g+1]),
			.out_side  (side_c[g+1])
		);
	end

	assign out_valid = vld_c[QUO_W];
	assign quo       = quo_c[QUO_W];
	assign out_side  = side_c[QUO_W];

endmodule

/* rtl/core/fractional_baud_divisor_calc.sv */
// Top level of the fractional baud divisor calculator: config registers, pipeline glue.
// Depends on fbdc_pkg, fbdc_divider and fractional_baud_divisor_calc_assert.svh.
//
//  Port group | Dir | Payload                                  | Transaction when
//  -----------+-----+------------------------------------------+-------------------------
//  s_*        | in  | s_tdata: baud_rate                       | s_tvalid && s_tready
//  m_*        | out | m_tdata: DL, bytes, N, word; tuser: code | m_tvalid && m_tready
//  cfg_*      | in  | cfg_index, cfg_data                      | cfg_valid && cfg_ready
//
// The pipeline has one input stage, 22 stages of the first divider (one quotient bit
// each), two stages for DL and the baud * DL product, 13 stages of the second divider
// and one output register. One transaction enters per cycle unless the output stalls.
// A stall at the output freezes every stage together, so nothing is lost or repeated.
// Reset clears valid bits and loads the register defaults.
`include "fractional_baud_divisor_calc_assert.svh"

module fractional_baud_divisor_calc import fbdc_pkg::*; #(
	parameter int DIVISOR_LIMIT = DIVISOR_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata, from bit 0: baud_rate[21:0], zero pad
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// m_tdata, from bit 0: divisor_latch[15:0], divisor_low_byte[7:0],
	// divisor_high_byte[7:0], fraction_n[10:0], fraction_word[15:0], zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	// m_tuser, from bit 0: status[1:0]
	output logic [STATUS_W-1:0]   m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DLF_W = DIV1_QUO_W + 1;

	logic [CLK_W-1:0] clock_hz_q;
	logic [MUL_W-1:0] frac_mult_q;

	logic advance;

	logic [BAUD_W-1:0]     baud_in;
	logic [MUL_W:0]        mult_plus;
	logic [DIV1_DEN_W-1:0] den1_in;

	logic                  valid_s1;
	logic [DIV1_DEN_W-1:0] den1_s1;
	side1_t                side1_s1;

	logic                  div1_valid;
	logic [DIV1_QUO_W-1:0] div1_quo;
	logic [$bits(side1_t)-1:0] div1_side_raw;
	side1_t                div1_side;

	logic [DLF_W-1:0]      dl_full;
	logic                  no_div;

	logic                  valid_s2;
	logic [DL_W-1:0]       dl_s2;
	logic                  no_div_s2;
	side1_t                side1_s2;

	logic                  valid_s3;
	logic [DIV2_NUM_W-1:0] num2_s3;
	logic [DIV2_DEN_W-1:0] den2_s3;
	side2_t                side2_s3;

	logic                  div2_valid;
	logic [DIV2_QUO_W-1:0] div2_quo;
	logic [$bits(side2_t)-1:0] div2_side_raw;
	side2_t                div2_side;

	logic [DIV2_QUO_W-1:0] frac_base;
	logic                  too_high;
	logic [FRAC_W-1:0]     n_calc;

	logic                  valid_s4;
	logic [DL_W-1:0]       dl_s4;
	logic [FRAC_W-1:0]     n_s4;
	logic [WORD_W-1:0]     word_s4;
	logic [STATUS_W-1:0]   status_s4;

	// Configuration: always ready, writes beyond the list drop silently
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q  <= CLOCK_HZ_RST;
			frac_mult_q <= FRAC_MULT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CLOCK_HZ:  clock_hz_q  <= cfg_data;
				CFG_FRAC_MULT: frac_mult_q <= cfg_data[MUL_W-1:0];
				default: ;
			endcase
		end
	end

	// Whole pipeline advances when the output register is free or being drained
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

	// Stage 1: first divisor 32 * (M + 1) * baud
	always_comb begin
		baud_in   = s_tdata[BAUD_W-1:0];
		mult_plus = (MUL_W + 1)'(frac_mult_q) + (MUL_W + 1)'(1);
		den1_in   = (DIV1_DEN_W'(baud_in) * DIV1_DEN_W'(mult_plus)) << DIV1_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			den1_s1         <= den1_in;
			side1_s1.baud   <= baud_in;
			side1_s1.clk_hz <= clock_hz_q;
			side1_s1.mult   <= frac_mult_q;
		end
	end

	// Quotient clock_hz / den1 is below 2^22 whenever baud is nonzero
	fbdc_divider #(
		.NUM_W  (DIV1_NUM_W),
		.DEN_W  (DIV1_DEN_W),
		.QUO_W  (DIV1_QUO_W),
		.SIDE_W ($bits(side1_t))
	) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (valid_s1),
		.num       (side1_s1.clk_hz),
		.den       (den1_s1),
		.in_side   (side1_s1),
		.out_valid (div1_valid),
		.quo       (div1_quo),
		.out_side  (div1_side_raw)
	);

	assign div1_side = side1_t'(div1_side_raw);

	// Stage 2: DL = quotient + 1, flag zero baud or DL at or above the limit
	always_comb begin
		dl_full = DLF_W'(div1_quo) + DLF_W'(1);
		no_div  = (div1_side.baud == '0) || (32'(dl_full) >= DIVISOR_LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= div1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dl_s2     <= dl_full[DL_W-1:0];
			no_div_s2 <= no_div;
			side1_s2  <= div1_side;
		end
	end

	// Stage 3: second numerator 64 * clock_hz and divisor baud * DL
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			num2_s3         <= DIV2_NUM_W'(side1_s2.clk_hz) << DIV2_SHIFT;
			den2_s3         <= DIV2_DEN_W'(side1_s2.baud) * DIV2_DEN_W'(dl_s2);
			side2_s3.dl     <= dl_s2;
			side2_s3.mult   <= side1_s2.mult;
			side2_s3.no_div <= no_div_s2;
		end
	end

	// For a valid DL the scaled quotient stays below 2048 * (M + 1), so 13 bits suffice
	fbdc_divider #(
		.NUM_W  (DIV2_NUM_W),
		.DEN_W  (DIV2_DEN_W),
		.QUO_W  (DIV2_QUO_W),
		.SIDE_W ($bits(side2_t))
	) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (valid_s3),
		.num       (num2_s3),
		.den       (den2_s3),
		.in_side   (side2_s3),
		.out_valid (div2_valid),
		.quo       (div2_quo),
		.out_side  (div2_side_raw)
	);

	assign div2_side = side2_t'(div2_side_raw);

	// Stage 4: N = scaled - 2048 * M, pick the status, zero every field on error
	always_comb begin
		frac_base = {div2_side.mult, FRAC_W'(0)};
		too_high  = div2_quo < frac_base;
		n_calc    = FRAC_W'(div2_quo - frac_base);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= div2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (div2_side.no_div) begin
				status_s4 <= ST_NO_DIV;
				dl_s4     <= '0;
				n_s4      <= '0;
				word_s4   <= '0;
			end else if (too_high) begin
				status_s4 <= ST_TOO_HIGH;
				dl_s4     <= '0;
				n_s4      <= '0;
				word_s4   <= '0;
			end else begin
				status_s4 <= ST_OK;
				dl_s4     <= div2_side.dl;
				n_s4      <= n_calc;
				word_s4   <= {1'b1, WORD_PAD_W'(0), div2_side.mult, n_calc};
			end
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tuser  = status_s4;
	assign m_tdata  = {OUT_PAD_W'(0), word_s4, n_s4,
		dl_s4[DL_W-1:BYTE_W], dl_s4[BYTE_W-1:0], dl_s4};

	`FBDC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_tvalid && s_tready, valid_s1, "accepted transaction missing from input stage")
	`FBDC_ASSERT_IMPL(a_ok_dl_nonzero, clk, arst_n, m_tvalid && (m_tuser == ST_OK), m_tdata[DL_W-1:0] != '0, "ok result with zero divisor")
	`FBDC_ASSERT_IMPL(a_ok_dl_limit, clk, arst_n, m_tvalid && (m_tuser == ST_OK), 32'(m_tdata[DL_W-1:0]) < DIVISOR_LIMIT, "ok result with divisor at or above limit")
	`FBDC_ASSERT_IMPL(a_err_zero, clk, arst_n, m_tvalid && (m_tuser != ST_OK), m_tdata == '0, "error result carries nonzero fields")

endmodule
